// ===== rtl/md4_block_compression_macros.svh =====
`ifndef MD4_BLOCK_COMPRESSION_MACROS_SVH
`define MD4_BLOCK_COMPRESSION_MACROS_SVH

// same-cycle implication, checked outside reset
`define MD4BC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MD4BC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/md4bc_pkg.sv =====
`default_nettype none

package md4bc_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] K_R1 = 32'h00000000;
    localparam logic [31:0] K_R2 = 32'h5a827999;
    localparam logic [31:0] K_R3 = 32'h6ed9eba1;

    localparam logic [5:0] LAST_STEP = 6'd47;
    localparam logic [3:0] LAST_WORD = 4'd15;
    localparam logic [1:0] LAST_OUT  = 2'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  index;
        logic        reload;
    } t_item;

    function automatic logic [3:0] f_order(input logic [1:0] rnd, input logic [3:0] pos);
        case (rnd)
            2'd0:    f_order = pos;
            2'd1:    f_order = {pos[1:0], pos[3:2]};
            default: f_order = {pos[0], pos[1], pos[2], pos[3]};
        endcase
    endfunction

    function automatic logic [4:0] f_rot(input logic [1:0] rnd, input logic [1:0] j);
        logic [4:0] r;
        r = 5'd3;
        case (rnd)
            2'd0: begin
                case (j)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd7;
                    2'd2:    r = 5'd11;
                    default: r = 5'd19;
                endcase
            end
            2'd1: begin
                case (j)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd5;
                    2'd2:    r = 5'd9;
                    default: r = 5'd13;
                endcase
            end
            default: begin
                case (j)
                    2'd0:    r = 5'd3;
                    2'd1:    r = 5'd9;
                    2'd2:    r = 5'd11;
                    default: r = 5'd15;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_const(input logic [1:0] rnd);
        case (rnd)
            2'd0:    f_const = K_R1;
            2'd1:    f_const = K_R2;
            default: f_const = K_R3;
        endcase
    endfunction

    function automatic logic [31:0] f_mix(input logic [1:0] rnd, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
        case (rnd)
            2'd0:    f_mix = (x & y) | (~x & z);
            2'd1:    f_mix = (x & y) | (x & z) | (y & z);
            default: f_mix = x ^ y ^ z;
        endcase
    endfunction

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md4bc_front.sv =====
`default_nettype none

module md4bc_front
    import md4bc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_message_word,
    input  wire logic        i_start_message,
    output logic             o_stall,
    output logic             o_push,
    output t_item            o_item,
    input  wire logic        i_q_full
);

    logic [3:0] r_count;
    logic [3:0] n_count;
    logic [3:0] w_index;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign w_index = i_start_message ? 4'd0 : r_count;
    assign n_count = w_index + 4'd1;

    always_comb begin
        o_item.word   = i_message_word;
        o_item.index  = w_index;
        o_item.reload = i_start_message;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/md4bc_fifo.sv =====
`default_nettype none

module md4bc_fifo
    import md4bc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_CW-1:0]   r_cnt;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_item    = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    function automatic logic [Q_AW-1:0] f_next(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= f_next(r_wptr);
            end
            if (w_do_pop) begin
                r_rptr <= f_next(r_rptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/md4bc_back.sv =====
`default_nettype none

module md4bc_back
    import md4bc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_item       i_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [1:0]       o_digest_index,
    output logic             o_digest_last
);

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_buf [16];
    logic [31:0] r_cv  [4];
    logic [31:0] r_wr  [4];
    logic [5:0]  r_step;
    logic [1:0]  r_out_idx;

    logic [1:0]  w_round;
    logic [3:0]  w_pos;
    logic [31:0] w_msg;
    logic [31:0] w_sum;
    logic [31:0] w_new_b;
    logic        w_take;
    logic        w_out_done;

    assign w_round = r_step[5:4];
    assign w_pos   = r_step[3:0];
    assign w_msg   = r_buf[f_order(w_round, w_pos)];
    assign w_sum   = r_wr[0] + f_mix(w_round, r_wr[1], r_wr[2], r_wr[3]) + w_msg
                     + f_const(w_round);
    assign w_new_b = f_rotl(w_sum, f_rot(w_round, w_pos[1:0]));

    assign o_digest_word  = r_cv[r_out_idx];
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = (r_out_idx == LAST_OUT);

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        o_valid    = 1'b0;
        w_take     = 1'b0;
        w_out_done = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_q_pop = 1'b1;
                w_take  = i_q_valid;
                if (i_q_valid && i_item.index == LAST_WORD) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall && r_out_idx == LAST_OUT) begin
                    w_out_done = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0]   <= IV_A;
            r_cv[1]   <= IV_B;
            r_cv[2]   <= IV_C;
            r_cv[3]   <= IV_D;
            r_step    <= '0;
            r_out_idx <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    r_step    <= '0;
                    r_out_idx <= '0;
                    if (w_take && i_item.reload) begin
                        r_cv[0] <= IV_A;
                        r_cv[1] <= IV_B;
                        r_cv[2] <= IV_C;
                        r_cv[3] <= IV_D;
                    end
                end
                ST_ROUND: begin
                    r_step <= r_step + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 4; i++) begin
                        r_cv[i] <= r_cv[i] + r_wr[i];
                    end
                end
                ST_OUT: begin
                    if (!i_stall && !w_out_done) begin
                        r_out_idx <= r_out_idx + 2'd1;
                    end
                end
                default: begin
                    r_step <= '0;
                end
            endcase
        end
    end

    // block buffer and working registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_buf[i_item.index] <= i_item.word;
            r_wr                <= r_cv;
        end else if (r_state == ST_ROUND) begin
            r_wr[0] <= r_wr[3];
            r_wr[1] <= w_new_b;
            r_wr[2] <= r_wr[1];
            r_wr[3] <= r_wr[2];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/md4_block_compression.sv =====
// once the sixteenth word of a block is loaded: the round steps, the add, then the digest output
// the four digest words follow one per cycle unless stalled
// the queue is popped only while loading; other words wait there, stalling the input when full
// the 48-step round loop runs one step per cycle on a single shared round unit
// reset: synchronous active low; queue and word count empty, chaining value at the initial value
`default_nettype none
`include "md4_block_compression_macros.svh"

module md4_block_compression
    import md4bc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_message_word,
    input  wire logic        i_start_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [1:0]       o_digest_index,
    output logic             o_digest_last
);

    t_item w_push_item;
    t_item w_q_item;
    logic  w_push;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_q_pop;

    md4bc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_message_word  (i_message_word),
        .i_start_message (i_start_message),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_item          (w_push_item),
        .i_q_full        (w_q_full)
    );

    md4bc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    md4bc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_item         (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    `MD4BC_ASSERT_NOW(a_no_pop_while_out, w_q_pop && w_q_valid, !o_valid, "item taken during output")
    `MD4BC_ASSERT_NEXT(a_last_ends_out, o_valid && !i_stall && o_digest_last, !o_valid, "output continues after last word")
    `MD4BC_ASSERT_NEXT(a_index_steps, o_valid && !i_stall && !o_digest_last, o_valid && (o_digest_index == $past(o_digest_index) + 2'd1), "digest index skipped")

endmodule

`default_nettype wire

// ===== verif/tb_md4_block_compression.sv =====
`timescale 1ns / 100ps

module tb_md4_block_compression;
    import md4bc_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic        typed;
    } dir_row_t;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    localparam int DIR_ROWS = 23;
    localparam int RAND_ITEMS = 500;
    localparam int DRAIN_CYCLES = 64;

    // digest of the empty message, words D C B A from msb down
    localparam logic [127:0] EMPTY_DIGEST =
        {32'hc089c0e0, 32'hd7593cb7, 32'h31e96ad1, 32'he0cfd631};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic        i_start_message = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_digest_index;
    logic        o_digest_last;

    md4_block_compression dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_message_word  (i_message_word),
        .i_start_message (i_start_message),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digest_word   (o_digest_word),
        .o_digest_index  (o_digest_index),
        .o_digest_last   (o_digest_last)
    );

    bit [31:0]   chain_val [4];
    bit [31:0]   msg_block [16];
    int unsigned words_taken;
    digest_t     digest_q [$];
    dir_row_t    dir_rows [DIR_ROWS];

    int          errors = 0;
    int          words_sent = 0;
    int          blocks_done = 0;
    int          restarts = 0;
    int          digests_seen = 0;
    int          burst_left = 0;
    stall_mode_e stall_mode = STALL_NONE;
    int          stall_tick = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit [31:0] round_mix(input int unsigned rnd, input bit [31:0] x,
                                            input bit [31:0] y, input bit [31:0] z);
        case (rnd)
            0:       return (x & y) | (~x & z);
            1:       return (x & y) | (x & z) | (y & z);
            default: return x ^ y ^ z;
        endcase
    endfunction

    function automatic bit [31:0] round_add(input int unsigned rnd);
        case (rnd)
            0:       return K_R1;
            1:       return K_R2;
            default: return K_R3;
        endcase
    endfunction

    function automatic int unsigned step_word(input int unsigned rnd, input int unsigned pos);
        int unsigned rev;
        rev = ((pos & 1) << 3) | ((pos & 2) << 1) | ((pos & 4) >> 1) | ((pos & 8) >> 3);
        case (rnd)
            0:       return pos;
            1:       return (pos % 4) * 4 + pos / 4;
            default: return rev;
        endcase
    endfunction

    function automatic int unsigned step_shift(input int unsigned rnd, input int unsigned j);
        case (rnd)
            0: begin
                case (j)
                    0:       return 3;
                    1:       return 7;
                    2:       return 11;
                    default: return 19;
                endcase
            end
            1: begin
                case (j)
                    0:       return 3;
                    1:       return 5;
                    2:       return 9;
                    default: return 13;
                endcase
            end
            default: begin
                case (j)
                    0:       return 3;
                    1:       return 9;
                    2:       return 11;
                    default: return 15;
                endcase
            end
        endcase
    endfunction

    function automatic bit [31:0] rotl32(input bit [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void md4_compress();
        bit [31:0]   r [4];
        bit [31:0]   a;
        int unsigned rnd;
        int unsigned pos;
        for (int i = 0; i < 4; i++) r[i] = chain_val[i];
        for (int unsigned t = 0; t < 48; t++) begin
            rnd = t / 16;
            pos = t % 16;
            a = r[0] + round_mix(rnd, r[1], r[2], r[3]) + msg_block[step_word(rnd, pos)]
                + round_add(rnd);
            a = rotl32(a, step_shift(rnd, pos % 4));
            r[0] = r[3];
            r[3] = r[2];
            r[2] = r[1];
            r[1] = a;
        end
        for (int i = 0; i < 4; i++) chain_val[i] += r[i];
    endfunction

    function automatic void absorb_word(input bit [31:0] w, input bit st, input bit typed);
        digest_t d;
        if (st) begin
            chain_val[0] = IV_A;
            chain_val[1] = IV_B;
            chain_val[2] = IV_C;
            chain_val[3] = IV_D;
            if (words_taken != 0) restarts++;
            words_taken = 0;
        end
        msg_block[words_taken] = w;
        words_taken++;
        if (words_taken == 16) begin
            words_taken = 0;
            md4_compress();
            blocks_done++;
            for (int k = 0; k < 4; k++) begin
                d.word  = typed ? EMPTY_DIGEST[k*32 +: 32] : chain_val[k];
                d.index = k[1:0];
                d.last  = (k == 3);
                digest_q.push_back(d);
            end
        end
    endfunction

    function automatic void check_digest();
        digest_t d;
        digests_seen++;
        if (digest_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest item word=%h index=%0d last=%0b", $time,
                     o_digest_word, o_digest_index, o_digest_last);
            return;
        end
        d = digest_q.pop_front();
        if (o_digest_word !== d.word) begin
            errors++;
            $display("%0t: digest_word expected %h actual %h", $time, d.word, o_digest_word);
        end
        if (o_digest_index !== d.index) begin
            errors++;
            $display("%0t: digest_index expected %0d actual %0d", $time, d.index,
                     o_digest_index);
        end
        if (o_digest_last !== d.last) begin
            errors++;
            $display("%0t: digest_last expected %0b actual %0b", $time, d.last,
                     o_digest_last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) check_digest();
        if (stall_tick == 0) begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            stall_tick <= $urandom_range(20, 150);
        end else begin
            stall_tick <= stall_tick - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
            default:     i_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_word(input bit [31:0] w, input bit st, input bit typed);
        i_valid         <= 1'b1;
        i_message_word  <= w;
        i_start_message <= st;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        absorb_word(w, st, typed);
        words_sent++;
        pace();
    endtask

    initial begin
        bit [31:0] w;
        bit        st;

        dir_rows = '{
            '{32'hFFFF_FFFF, 1'b1, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            // restart in mid-block: empty message, padded
            '{32'h0000_0080, 1'b1, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
            '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b1},
            // restart on a block boundary
            '{32'hFFFF_FFFF, 1'b1, 1'b0}, '{32'h8000_0000, 1'b0, 1'b0},
            '{32'h0000_0001, 1'b0, 1'b0}
        };

        chain_val[0] = IV_A;
        chain_val[1] = IV_B;
        chain_val[2] = IV_C;
        chain_val[3] = IV_D;
        words_taken = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].word, dir_rows[i].start, dir_rows[i].typed);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0:       w = 32'h0000_0000;
                1:       w = 32'hFFFF_FFFF;
                2:       w = 32'h1 << $urandom_range(0, 31);
                default: w = $urandom;
            endcase
            if (words_taken == 0)
                st = ($urandom_range(0, 1) == 0);
            else
                st = ($urandom_range(0, 39) == 0);
            send_word(w, st, 1'b0);
        end

        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d message words: %0d blocks compressed, %0d mid-block restarts",
                 words_sent, blocks_done, restarts);
        $display("checked %0d digest items under random gaps and stalls", digests_seen);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
